[rtl/core/rrts_pkg.sv]
package rrts_pkg;

  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_SPAWN     = 3'd1,
    CMD_TERMINATE = 3'd2,
    CMD_BLOCK     = 3'd3,
    CMD_RESUME    = 3'd4,
    CMD_SLEEP     = 3'd5,
    CMD_QUERY     = 3'd6,
    CMD_NOP       = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_SUCH  = 3'd1,
    ST_MAIN     = 3'd2,
    ST_FULL     = 3'd3,
    ST_SHUTDOWN = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_SPAWN_SCAN,
    S_DEQ_RD,
    S_DEQ_CHK,
    S_SW_CUR,
    S_SW_REQ,
    S_SW_RD,
    S_SW_UPD,
    S_SW_HRD,
    S_SW_HEAD,
    S_SW_QRD,
    S_SW_QNT,
    S_OUT
  } state_t;

  localparam int FlagLive     = 0;
  localparam int FlagBlocked  = 1;
  localparam int FlagSleeping = 2;
  localparam int FlagQueued   = 3;

  localparam logic [31:0] Sat32 = 32'hFFFF_FFFF;
  localparam logic [15:0] Sat16 = 16'hFFFF;

endpackage

[rtl/core/round_robin_thread_scheduler.sv]
// Round-robin thread scheduler.
// Input channel (in_valid/in_ready) carries one event: command, thread_id,
// sleep_count. Output channel (out_valid/out_ready) returns one result per
// event: status, new_id, running_id, switched, thread_quanta, total_quanta.
// quantum_ticks is written through cfg_we/cfg_data; the user must do so only
// while no event is in flight, as the block does not enforce it. The thread
// table (flags, sleep counter, quanta) sits in one synchronous memory, the
// ready queue in another; both register their read data. A simple event
// passes the read, execute and output states. A spawn scans the table from
// entry 1 until it finds a free entry or reaches the last one. Removing a
// thread from the queue walks the queue, reading and checking each entry and
// moving later entries down. A context switch requeues the running thread if
// it can still run, walks every table entry, then removes the new head.
// One event is handled at a time: in_ready is high only when the engine is idle
// and the output register is empty. Reset (rst, synchronous) is followed by a
// clearing pass over every thread table entry with in_ready low; then
// thread 0 runs. A stalled receiver holds the result in the output register;
// no new event is taken until it transfers.
module round_robin_thread_scheduler #(
  parameter int MAX_THREADS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  command,
  input  logic [5:0]  thread_id,
  input  logic [15:0] sleep_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [5:0]  new_id,
  output logic [5:0]  running_id,
  output logic        switched,
  output logic [31:0] thread_quanta,
  output logic [31:0] total_quanta,
  input  logic        cfg_we,
  input  logic [19:0] cfg_data
);

  localparam int IW = $clog2(MAX_THREADS);
  localparam int LW = $clog2(MAX_THREADS + 1);
  localparam int EW = 4 + 16 + 32;
  localparam logic [IW-1:0] LastId = IW'(MAX_THREADS - 1);

  // entry: {quanta, sleep, flags}
  logic [EW-1:0] tbl [MAX_THREADS];
  logic [IW-1:0] queue_mem [MAX_THREADS];

  logic          t_we;
  logic [IW-1:0] t_waddr, t_raddr;
  logic [EW-1:0] t_wdata, t_rdata;
  logic          q_we;
  logic [IW-1:0] q_waddr, q_raddr;
  logic [IW-1:0] q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (t_we) tbl[t_waddr] <= t_wdata;
    t_rdata <= tbl[t_raddr];
  end

  always_ff @(posedge clk) begin
    if (q_we) queue_mem[q_waddr] <= q_wdata;
    q_rdata <= queue_mem[q_raddr];
  end

  rrts_pkg::state_t state, state_next;

  logic          init;
  logic [IW-1:0] init_idx;
  logic [19:0]   quantum_ticks;
  logic [LW-1:0] qlen, qlen_next;
  logic [5:0]    cur, cur_next;
  logic [31:0]   qtotal, qtotal_next;
  logic [19:0]   tick_count, tick_count_next;

  logic [2:0]    r_cmd;
  logic [5:0]    r_tid;
  logic [15:0]   r_cnt;
  logic [2:0]    r_status, r_status_next;
  logic [5:0]    r_newid, r_newid_next;
  logic          r_sw, r_sw_next;
  logic [31:0]   r_tq, r_tq_next;
  logic          r_after, r_after_next;  // switch after dequeue
  logic          r_head, r_head_next;    // dequeue removes the new head
  logic [IW-1:0] deq_id, deq_id_next;
  logic [LW-1:0] idx, idx_next;
  logic          found, found_next;

  logic [3:0]    e_flags;
  logic [15:0]   e_sleep;
  logic [31:0]   e_quanta;
  assign e_flags  = t_rdata[3:0];
  assign e_sleep  = t_rdata[19:4];
  assign e_quanta = t_rdata[51:20];

  logic          tid_ok;
  logic [IW-1:0] tid_i, cur_i;
  assign tid_ok = ({26'd0, r_tid} < 32'(MAX_THREADS));
  assign tid_i  = r_tid[IW-1:0];
  assign cur_i  = cur[IW-1:0];

  logic [16:0]   sleep_sum;
  logic [19:0]   tick_inc, quantum_eff;
  logic [31:0]   quanta_inc;
  assign sleep_sum   = {1'b0, e_sleep} + {1'b0, r_cnt};
  assign tick_inc    = tick_count + 20'd1;
  assign quantum_eff = (quantum_ticks == '0) ? 20'd1 : quantum_ticks;
  assign quanta_inc  = (e_quanta == rrts_pkg::Sat32) ? e_quanta : e_quanta + 32'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      init          <= 1'b1;
      init_idx      <= '0;
      quantum_ticks <= 20'd1;
    end else begin
      if (cfg_we) quantum_ticks <= cfg_data;
      if (init) begin
        init_idx <= init_idx + 1'b1;
        if (init_idx == LastId) init <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= rrts_pkg::S_IDLE;
      qlen       <= '0;
      cur        <= '0;
      qtotal     <= 32'd1;
      tick_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      qlen       <= qlen_next;
      cur        <= cur_next;
      qtotal     <= qtotal_next;
      tick_count <= tick_count_next;
      if (state == rrts_pkg::S_OUT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      r_cmd <= command;
      r_tid <= thread_id;
      r_cnt <= sleep_count;
    end
    r_status <= r_status_next;
    r_newid  <= r_newid_next;
    r_sw     <= r_sw_next;
    r_tq     <= r_tq_next;
    r_after  <= r_after_next;
    r_head   <= r_head_next;
    deq_id   <= deq_id_next;
    idx      <= idx_next;
    found    <= found_next;
    if (state == rrts_pkg::S_OUT) begin
      status        <= r_status;
      new_id        <= r_newid;
      running_id    <= cur;
      switched      <= r_sw;
      thread_quanta <= r_tq;
      total_quanta  <= qtotal;
    end
  end

  assign in_ready = !init && state == rrts_pkg::S_IDLE && !out_valid;

  always_comb begin
    state_next      = state;
    qlen_next       = qlen;
    cur_next        = cur;
    qtotal_next     = qtotal;
    tick_count_next = tick_count;
    r_status_next   = r_status;
    r_newid_next    = r_newid;
    r_sw_next       = r_sw;
    r_tq_next       = r_tq;
    r_after_next    = r_after;
    r_head_next     = r_head;
    deq_id_next     = deq_id;
    idx_next        = idx;
    found_next      = found;
    t_we    = 1'b0;
    t_waddr = tid_i;
    t_wdata = t_rdata;
    t_raddr = tid_i;
    q_we    = 1'b0;
    q_waddr = qlen[IW-1:0];
    q_wdata = tid_i;
    q_raddr = idx[IW-1:0];

    if (init) begin
      t_we    = 1'b1;
      t_waddr = init_idx;
      t_wdata = (init_idx == '0) ? {32'd1, 16'd0, 4'b0001} : '0;
    end

    unique case (state)
      rrts_pkg::S_IDLE: begin
        if (in_valid && in_ready) state_next = rrts_pkg::S_READ;
      end
      rrts_pkg::S_READ: begin
        r_status_next = rrts_pkg::ST_OK;
        r_newid_next  = '0;
        r_sw_next     = 1'b0;
        r_tq_next     = '0;
        r_after_next  = 1'b0;
        r_head_next   = 1'b0;
        idx_next      = '0;
        found_next    = 1'b0;
        t_raddr = (r_cmd == rrts_pkg::CMD_SLEEP) ? cur_i : tid_i;
        if (r_cmd == rrts_pkg::CMD_SPAWN) begin
          t_raddr    = IW'(1);
          idx_next   = LW'(1);
          state_next = rrts_pkg::S_SPAWN_SCAN;
        end else begin
          state_next = rrts_pkg::S_EXEC;
        end
      end
      rrts_pkg::S_EXEC: begin
        state_next = rrts_pkg::S_OUT;
        case (r_cmd)
          rrts_pkg::CMD_TICK: begin
            tick_count_next = tick_inc;
            if (tick_inc >= quantum_eff) begin
              r_sw_next  = 1'b1;
              state_next = rrts_pkg::S_SW_CUR;
            end
          end
          rrts_pkg::CMD_TERMINATE: begin
            if (!tid_ok || !e_flags[rrts_pkg::FlagLive]) begin
              r_status_next = rrts_pkg::ST_NO_SUCH;
            end else if (r_tid == '0) begin
              r_status_next = rrts_pkg::ST_SHUTDOWN;
            end else begin
              t_we    = 1'b1;
              t_wdata = '0;
              deq_id_next  = tid_i;
              r_after_next = (r_tid == cur);
              state_next   = rrts_pkg::S_DEQ_RD;
            end
          end
          rrts_pkg::CMD_BLOCK: begin
            if (r_tid == '0) begin
              r_status_next = rrts_pkg::ST_MAIN;
            end else if (!tid_ok || !e_flags[rrts_pkg::FlagLive]) begin
              r_status_next = rrts_pkg::ST_NO_SUCH;
            end else begin
              t_we = 1'b1;
              t_wdata[rrts_pkg::FlagBlocked] = 1'b1;
              t_wdata[rrts_pkg::FlagQueued]  = 1'b0;
              deq_id_next  = tid_i;
              r_after_next = (r_tid == cur);
              state_next   = rrts_pkg::S_DEQ_RD;
            end
          end
          rrts_pkg::CMD_RESUME: begin
            if (!tid_ok || !e_flags[rrts_pkg::FlagLive]) begin
              r_status_next = rrts_pkg::ST_NO_SUCH;
            end else begin
              t_we = 1'b1;
              t_wdata[rrts_pkg::FlagBlocked] = 1'b0;
              if (!e_flags[rrts_pkg::FlagSleeping] && !e_flags[rrts_pkg::FlagQueued] &&
                  r_tid != cur && qlen < LW'(MAX_THREADS)) begin
                t_wdata[rrts_pkg::FlagQueued] = 1'b1;
                q_we      = 1'b1;
                q_wdata   = tid_i;
                qlen_next = qlen + 1'b1;
              end
            end
          end
          rrts_pkg::CMD_SLEEP: begin
            if (cur == '0) begin
              r_status_next = rrts_pkg::ST_MAIN;
            end else begin
              t_we    = 1'b1;
              t_waddr = cur_i;
              t_wdata[rrts_pkg::FlagSleeping] = 1'b1;
              t_wdata[19:4] = sleep_sum[16] ? rrts_pkg::Sat16 : sleep_sum[15:0];
              r_sw_next  = 1'b1;
              state_next = rrts_pkg::S_SW_CUR;
            end
          end
          rrts_pkg::CMD_QUERY: begin
            if (!tid_ok || !e_flags[rrts_pkg::FlagLive]) r_status_next = rrts_pkg::ST_NO_SUCH;
            else r_tq_next = e_quanta;
          end
          default: ;
        endcase
      end
      rrts_pkg::S_SPAWN_SCAN: begin
        // t_rdata holds entry idx
        if (!e_flags[rrts_pkg::FlagLive]) begin
          t_we    = 1'b1;
          t_waddr = idx[IW-1:0];
          t_wdata = {32'd0, 16'd0, 4'b0001};
          r_newid_next = 6'(idx);
          if (qlen < LW'(MAX_THREADS)) begin
            t_wdata[rrts_pkg::FlagQueued] = 1'b1;
            q_we      = 1'b1;
            q_wdata   = idx[IW-1:0];
            qlen_next = qlen + 1'b1;
          end
          state_next = rrts_pkg::S_OUT;
        end else if (idx == LW'(MAX_THREADS - 1)) begin
          r_status_next = rrts_pkg::ST_FULL;
          state_next    = rrts_pkg::S_OUT;
        end else begin
          t_raddr  = IW'(idx + 1'b1);
          idx_next = idx + 1'b1;
        end
      end
      rrts_pkg::S_DEQ_RD: begin
        if (idx >= qlen) begin
          if (found) qlen_next = qlen - 1'b1;
          if (r_head) begin
            state_next = rrts_pkg::S_SW_QRD;
          end else if (r_after) begin
            r_sw_next  = 1'b1;
            state_next = rrts_pkg::S_SW_CUR;
          end else begin
            state_next = rrts_pkg::S_OUT;
          end
        end else begin
          q_raddr    = idx[IW-1:0];
          state_next = rrts_pkg::S_DEQ_CHK;
        end
      end
      rrts_pkg::S_DEQ_CHK: begin
        // q_rdata = queue[idx]; entries past the match move down one slot
        if (found) begin
          q_we    = 1'b1;
          q_waddr = IW'(idx - 1'b1);
          q_wdata = q_rdata;
        end else if (q_rdata == deq_id) begin
          found_next = 1'b1;
        end
        idx_next   = idx + 1'b1;
        state_next = rrts_pkg::S_DEQ_RD;
      end
      rrts_pkg::S_SW_CUR: begin
        t_raddr    = cur_i;
        state_next = rrts_pkg::S_SW_REQ;
      end
      rrts_pkg::S_SW_REQ: begin
        // requeue the running thread if it can still run
        if (e_flags[rrts_pkg::FlagLive] && !e_flags[rrts_pkg::FlagBlocked] &&
            !e_flags[rrts_pkg::FlagSleeping] && !e_flags[rrts_pkg::FlagQueued] &&
            qlen < LW'(MAX_THREADS)) begin
          t_we    = 1'b1;
          t_waddr = cur_i;
          t_wdata[rrts_pkg::FlagQueued] = 1'b1;
          q_we      = 1'b1;
          q_wdata   = cur_i;
          qlen_next = qlen + 1'b1;
        end
        idx_next   = '0;
        state_next = rrts_pkg::S_SW_RD;
      end
      rrts_pkg::S_SW_RD: begin
        t_raddr    = idx[IW-1:0];
        state_next = rrts_pkg::S_SW_UPD;
      end
      rrts_pkg::S_SW_UPD: begin
        t_waddr = idx[IW-1:0];
        if (e_flags[rrts_pkg::FlagLive] && e_flags[rrts_pkg::FlagSleeping]) begin
          t_we = 1'b1;
          if (e_sleep == '0) begin
            t_wdata[rrts_pkg::FlagSleeping] = 1'b0;
            if (!e_flags[rrts_pkg::FlagBlocked] && !e_flags[rrts_pkg::FlagQueued] &&
                qlen < LW'(MAX_THREADS)) begin
              t_wdata[rrts_pkg::FlagQueued] = 1'b1;
              q_we      = 1'b1;
              q_wdata   = idx[IW-1:0];
              qlen_next = qlen + 1'b1;
            end
          end else begin
            t_wdata[19:4] = e_sleep - 16'd1;
          end
        end
        if (idx == LW'(MAX_THREADS - 1)) begin
          state_next = rrts_pkg::S_SW_HRD;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = rrts_pkg::S_SW_RD;
        end
      end
      rrts_pkg::S_SW_HRD: begin
        q_raddr    = '0;
        state_next = rrts_pkg::S_SW_HEAD;
      end
      rrts_pkg::S_SW_HEAD: begin
        if (qlen == '0) begin
          cur_next   = '0;
          state_next = rrts_pkg::S_SW_QRD;
        end else begin
          cur_next    = 6'(q_rdata);
          deq_id_next = q_rdata;
          idx_next    = '0;
          found_next  = 1'b0;
          r_head_next = 1'b1;
          state_next  = rrts_pkg::S_DEQ_RD;
        end
      end
      rrts_pkg::S_SW_QRD: begin
        t_raddr    = cur_i;
        state_next = rrts_pkg::S_SW_QNT;
      end
      rrts_pkg::S_SW_QNT: begin
        t_we    = 1'b1;
        t_waddr = cur_i;
        t_wdata[51:20] = quanta_inc;
        t_wdata[rrts_pkg::FlagQueued] = 1'b0;
        qtotal_next     = (qtotal == rrts_pkg::Sat32) ? qtotal : qtotal + 32'd1;
        tick_count_next = '0;
        state_next      = rrts_pkg::S_OUT;
      end
      rrts_pkg::S_OUT: begin
        state_next = rrts_pkg::S_IDLE;
      end
      default: state_next = rrts_pkg::S_IDLE;
    endcase
  end

endmodule
